[sv/skoc_pkg.sv]
// Shared types, constants and helpers for the sorted key occurrence counter.
// No dependencies; imported by every module of the block.
package skoc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int COUNT_WIDTH = 16;
	localparam int HIGH_W      = 34;
	localparam int LOW_W       = 54;
	localparam int KEY_W       = HIGH_W + LOW_W;
	localparam int OCC_W       = 16;
	localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int SAT_W       = COUNT_WIDTH + OCC_W;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	typedef logic [KEY_W-1:0]       key_t;
	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [USED_W-1:0]      used_t;
	typedef logic [OCC_W-1:0]       occ_t;

	localparam cnt_t  CNT_MAX  = '1;
	localparam occ_t  OCC_MAX  = '1;
	localparam used_t USED_FULL = USED_W'(TABLE_DEPTH);

	typedef enum logic {
		OP_INSERT,
		OP_FLUSH
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_FLUSH
	} back_state_t;

	typedef struct packed {
		op_t  op;
		key_t key;
	} cmd_t;

	typedef struct packed {
		logic ins;
		logic shl;
		logic clr_ovf;
	} cell_ctl_t;

	typedef struct packed {
		key_t  head_key;
		cnt_t  head_cnt;
		used_t used;
		logic  ovf;
	} cell_stat_t;

	function automatic occ_t occ_sat(input cnt_t c);
		logic [SAT_W-1:0] wide;
		wide = SAT_W'(c);
		if (wide > SAT_W'(OCC_MAX)) begin
			return OCC_MAX;
		end
		return wide[OCC_W-1:0];
	endfunction

endpackage

[sv/skoc_front.sv]
// Front end: accepts items, classifies the action and queues commands.
// Depends on skoc_pkg.
module skoc_front import skoc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                action,
	input  logic [HIGH_W-1:0]   account_high,
	input  logic [LOW_W-1:0]    account_low,
	output logic                cmd_valid,
	output cmd_t                cmd,
	input  logic                cmd_take
);

	cmd_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr_en;
	logic              rd_en;
	cmd_t              new_cmd;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QDEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;
	assign cmd       = q_mem[rd_ptr_q];

	always_comb begin
		new_cmd.op  = (action == ACT_FLUSH) ? OP_FLUSH : OP_INSERT;
		new_cmd.key = {account_high, account_low};
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[sv/skoc_cells.sv]
// Row of compare-and-shift cells holding distinct keys in ascending order.
// Depends on skoc_pkg; driven by skoc_back.
module skoc_cells import skoc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  key_t       key,
	output cell_stat_t stat
);

	key_t  key_q [TABLE_DEPTH];
	cnt_t  cnt_q [TABLE_DEPTH];
	used_t used_q;
	logic  ovf_q;

	logic [TABLE_DEPTH-1:0] valid;
	logic [TABLE_DEPTH-1:0] lt;
	logic [TABLE_DEPTH-1:0] eq;
	logic [TABLE_DEPTH-1:0] lt_prev;
	key_t                   prev_key [TABLE_DEPTH];
	cnt_t                   prev_cnt [TABLE_DEPTH];
	key_t                   next_key [TABLE_DEPTH];
	cnt_t                   next_cnt [TABLE_DEPTH];
	logic                   hit;
	logic                   tbl_full;

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			valid[i] = (USED_W'(i) < used_q);
			lt[i]    = !valid[i] || (key < key_q[i]);
			eq[i]    = valid[i] && (key == key_q[i]);
		end
		lt_prev[0]  = 1'b0;
		prev_key[0] = key;
		prev_cnt[0] = cnt_t'(1);
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			lt_prev[i]  = lt[i-1];
			prev_key[i] = key_q[i-1];
			prev_cnt[i] = cnt_q[i-1];
		end
		for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
			next_key[i] = key_q[i+1];
			next_cnt[i] = cnt_q[i+1];
		end
		next_key[TABLE_DEPTH-1] = key_q[TABLE_DEPTH-1];
		next_cnt[TABLE_DEPTH-1] = cnt_q[TABLE_DEPTH-1];
	end

	assign hit      = |eq;
	assign tbl_full = (used_q == USED_FULL);

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (ctl.ins) begin
				if (hit) begin
					if (eq[i] && (cnt_q[i] != CNT_MAX)) begin
						cnt_q[i] <= cnt_q[i] + 1'b1;
					end
				end else if (!tbl_full) begin
					if (lt[i] && !lt_prev[i]) begin
						key_q[i] <= key;
						cnt_q[i] <= cnt_t'(1);
					end else if (lt_prev[i]) begin
						key_q[i] <= prev_key[i];
						cnt_q[i] <= prev_cnt[i];
					end
				end
			end else if (ctl.shl) begin
				key_q[i] <= next_key[i];
				cnt_q[i] <= next_cnt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (ctl.ins && !hit) begin
				if (tbl_full) begin
					ovf_q <= 1'b1;
				end else begin
					used_q <= used_q + 1'b1;
				end
			end else if (ctl.shl) begin
				used_q <= used_q - 1'b1;
			end
			if (ctl.clr_ovf) begin
				ovf_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.head_key = key_q[0];
		stat.head_cnt = cnt_q[0];
		stat.used     = used_q;
		stat.ovf      = ovf_q;
	end

endmodule

[sv/skoc_back.sv]
// Back end: sequences inserts and flushes on the cell row, holds the result register.
// Depends on skoc_pkg and skoc_cells.
module skoc_back import skoc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_take,
	output logic              empty,
	input  logic              pop,
	output logic [HIGH_W-1:0] key_high,
	output logic [LOW_W-1:0]  key_low,
	output logic [OCC_W-1:0]  occurrences,
	output logic              table_overflow,
	output logic              last
);

	back_state_t state_q;
	back_state_t state_d;
	cell_ctl_t   ctl;
	cell_stat_t  stat;
	logic        out_valid_q;
	logic        out_free;
	logic        emit;
	logic        emit_zero;
	logic        emit_last;

	skoc_cells u_cells (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.key    (cmd.key),
		.stat   (stat)
	);

	assign empty    = !out_valid_q;
	assign out_free = !out_valid_q || pop;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && (cmd.op == OP_FLUSH) && (stat.used != '0)) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (out_free && (stat.used == used_t'(1))) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_take    = 1'b0;
		ctl         = '0;
		emit        = 1'b0;
		emit_zero   = 1'b0;
		emit_last   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_INSERT) begin
						cmd_take = 1'b1;
						ctl.ins  = 1'b1;
					end else if (stat.used != '0) begin
						cmd_take = 1'b1;
					end else if (out_free) begin
						cmd_take    = 1'b1;
						emit        = 1'b1;
						emit_zero   = 1'b1;
						emit_last   = 1'b1;
						ctl.clr_ovf = 1'b1;
					end
				end
			end
			BK_FLUSH: begin
				if (out_free) begin
					emit        = 1'b1;
					ctl.shl     = 1'b1;
					emit_last   = (stat.used == used_t'(1));
					ctl.clr_ovf = emit_last;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			key_high       <= emit_zero ? '0 : stat.head_key[KEY_W-1:LOW_W];
			key_low        <= emit_zero ? '0 : stat.head_key[LOW_W-1:0];
			occurrences    <= emit_zero ? '0 : occ_sat(stat.head_cnt);
			table_overflow <= stat.ovf;
			last           <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/sorted_key_occurrence_counter_core.sv]
// Sorted key occurrence counter: queue front end, cell-row back end, result register.
// Depends on skoc_pkg, skoc_front, skoc_back (which holds skoc_cells).
// Throughput: one insert per cycle while no flush is in progress; a flush of N stored keys
// emits N results, one per cycle while the result register is free, each taken from the head
// of the cell row; a flush of an empty table emits a single result with zero key and count.
// Reset clears the command queue, fill count, overflow flag and result valid; no sweep.
module sorted_key_occurrence_counter_core import skoc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic [HIGH_W-1:0] account_high,
	input  logic [LOW_W-1:0]  account_low,
	output logic              empty,
	input  logic              pop,
	output logic [HIGH_W-1:0] key_high,
	output logic [LOW_W-1:0]  key_low,
	output logic [OCC_W-1:0]  occurrences,
	output logic              table_overflow,
	output logic              last
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;

	skoc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.account_high (account_high),
		.account_low  (account_low),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	skoc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_take       (cmd_take),
		.empty          (empty),
		.pop            (pop),
		.key_high       (key_high),
		.key_low        (key_low),
		.occurrences    (occurrences),
		.table_overflow (table_overflow),
		.last           (last)
	);

endmodule
